// ===== sv/gsc_pkg.sv =====
package gsc_pkg;

  // Input transaction payload
  typedef struct packed {
    logic               cmd;
    logic        [11:0] cell_index;
    logic signed [7:0]  cell_value;
    logic        [5:0]  from_x;
    logic        [5:0]  from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    logic       blocked;
    logic [1:0] reason;
  } out_t;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // Obstacle code after reset
  localparam logic signed [7:0] OBSTACLE_RESET = 8'sd100;

  typedef enum logic [1:0] {
    RS_FREE          = 2'd0,
    RS_OUT_OF_BOUNDS = 2'd1,
    RS_END_OCCUPIED  = 2'd2,
    RS_PATH_OCCUPIED = 2'd3
  } reason_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_END_CMP,
    ST_WALK,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    clear_en;
    logic    wr_cell;
    logic    capture;
    logic    start;
    logic    walk;
    logic    set_reason;
    reason_t reason;
    logic    load_result;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic oob;
    logic end_hit;
    logic zero_len;
    logic walk_hit;
    logic walk_done;
  } ctl_sts_t;

endpackage

// ===== sv/gsc_ctrl.sv =====
module gsc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_is_check,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  gsc_pkg::ctl_sts_t sts,
  output gsc_pkg::ctl_cmd_t cmd
);
  import gsc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output slot registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_is_check) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_CHECK;
          end else begin
            cmd.wr_cell = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (sts.oob) begin
          cmd.set_reason = 1'b1;
          cmd.reason     = RS_OUT_OF_BOUNDS;
          state_nxt      = ST_FINISH;
        end else begin
          cmd.start = 1'b1;
          state_nxt = ST_END_CMP;
        end
      end
      ST_END_CMP: begin
        if (sts.end_hit) begin
          cmd.set_reason = 1'b1;
          cmd.reason     = RS_END_OCCUPIED;
          state_nxt      = ST_FINISH;
        end else if (sts.zero_len) begin
          cmd.set_reason = 1'b1;
          cmd.reason     = RS_FREE;
          state_nxt      = ST_FINISH;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_hit) begin
          cmd.set_reason = 1'b1;
          cmd.reason     = RS_PATH_OCCUPIED;
          state_nxt      = ST_FINISH;
        end else if (sts.walk_done) begin
          cmd.set_reason = 1'b1;
          cmd.reason     = RS_FREE;
          state_nxt      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hand the result over once the output slot is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_result = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/gsc_dp.sv =====
module gsc_dp #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gsc_pkg::in_t       in_data,
  input  logic               cfg_wr_en,
  input  logic signed [7:0]  cfg_wr_data,
  input  gsc_pkg::ctl_cmd_t  cmd,
  output gsc_pkg::ctl_sts_t  sts,
  output gsc_pkg::out_t      out_data
);
  import gsc_pkg::*;

  localparam int CELL_COUNT = GRID_W * GRID_H;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int XW = $clog2(GRID_W);
  localparam int YW = $clog2(GRID_H);
  localparam int SW = (XW > YW) ? XW : YW;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(GRID_W);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELL_COUNT - 1);

  // Grid memory
  logic [7:0] mem [CELL_COUNT];
  logic [AW-1:0] wr_addr, rd_addr, clr_cnt_r;
  logic [7:0]    wr_data, rd_data_r;
  logic          wr_en, wr_ok;

  // Configuration and captured check
  logic signed [7:0]  obst_r;
  logic        [5:0]  fx_r, fy_r;
  logic signed [15:0] tx_r, ty_r;

  // Walk state
  logic [XW-1:0] ax_r, qx_r;
  logic [YW-1:0] ay_r, qy_r;
  logic [SW-1:0] rx_r, ry_r, steps_r, cnt_r;
  logic          xneg_r, yneg_r, pend_r;
  reason_t       reason_r;
  out_t          out_r;

  logic [XW-1:0] fx_g, tx_g, ax, sx;
  logic [YW-1:0] fy_g, ty_g, ay, sy;
  logic signed [XW:0] dx;
  logic signed [YW:0] dy;
  logic [SW-1:0] steps;
  logic [SW:0]   rx_sum, ry_sum;
  logic          issue, cell_hit;

  function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] x, input logic [AW-1:0] y);
    cell_addr = y * ROW_STRIDE + x;
  endfunction

  // Obstacle code register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obst_r <= OBSTACLE_RESET;
    end else if (cfg_wr_en) begin
      obst_r <= cfg_wr_data;
    end
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Write port: clear sweep or cell write
  assign wr_ok   = (32'(in_data.cell_index) < CELL_COUNT);
  assign wr_en   = cmd.clear_en || (cmd.wr_cell && wr_ok);
  assign wr_addr = cmd.clear_en ? clr_cnt_r : AW'(in_data.cell_index);
  assign wr_data = cmd.clear_en ? 8'd0 : in_data.cell_value;

  // Read port: end cell on start, otherwise current sample
  assign rd_addr = cmd.start ? cell_addr(AW'(tx_g), AW'(ty_g))
                             : cell_addr(AW'(sx), AW'(sy));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // Capture check coordinates
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fx_r <= in_data.from_x;
      fy_r <= in_data.from_y;
      tx_r <= in_data.to_x;
      ty_r <= in_data.to_y;
    end
  end

  // Coordinates on the grid; deltas, magnitudes and step count
  assign fx_g  = XW'(fx_r);
  assign fy_g  = YW'(fy_r);
  assign tx_g  = tx_r[XW-1:0];
  assign ty_g  = ty_r[YW-1:0];
  assign dx    = $signed({1'b0, tx_g}) - $signed({1'b0, fx_g});
  assign dy    = $signed({1'b0, ty_g}) - $signed({1'b0, fy_g});
  assign ax    = dx[XW] ? XW'(-dx) : XW'(dx);
  assign ay    = dy[YW] ? YW'(-dy) : YW'(dy);
  assign steps = (SW'(ax) > SW'(ay)) ? SW'(ax) : SW'(ay);

  // Current sample: start plus signed quotient on each axis
  assign sx = xneg_r ? (fx_g - qx_r) : (fx_g + qx_r);
  assign sy = yneg_r ? (fy_g - qy_r) : (fy_g + qy_r);

  // Remainders advance by |d|; one subtract keeps them below steps
  assign rx_sum = {1'b0, rx_r} + (SW+1)'(ax_r);
  assign ry_sum = {1'b0, ry_r} + (SW+1)'(ay_r);
  assign issue  = cmd.walk && (cnt_r < steps_r);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ax_r    <= ax;
      ay_r    <= ay;
      xneg_r  <= dx[XW];
      yneg_r  <= dy[YW];
      steps_r <= steps;
      cnt_r   <= '0;
      qx_r    <= '0;
      qy_r    <= '0;
      rx_r    <= '0;
      ry_r    <= '0;
    end else if (issue) begin
      cnt_r <= cnt_r + 1'b1;
      if (rx_sum >= {1'b0, steps_r}) begin
        rx_r <= SW'(rx_sum - {1'b0, steps_r});
        qx_r <= qx_r + 1'b1;
      end else begin
        rx_r <= SW'(rx_sum);
      end
      if (ry_sum >= {1'b0, steps_r}) begin
        ry_r <= SW'(ry_sum - {1'b0, steps_r});
        qy_r <= qy_r + 1'b1;
      end else begin
        ry_r <= SW'(ry_sum);
      end
    end
  end

  // Track the sample read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= issue;
    end
  end

  // Reason and result registers
  always_ff @(posedge clk) begin
    if (cmd.set_reason) reason_r <= cmd.reason;
    if (cmd.load_result) begin
      out_r.blocked <= (reason_r != RS_FREE);
      out_r.reason  <= reason_r;
    end
  end

  assign out_data = out_r;
  assign cell_hit = (rd_data_r == obst_r);

  // Status back to the controller
  always_comb begin
    sts.clear_last = (clr_cnt_r == LAST_CELL);
    sts.oob        = !( !tx_r[15] && (32'($unsigned(tx_r)) < GRID_W)
                     && !ty_r[15] && (32'($unsigned(ty_r)) < GRID_H)
                     && (32'(fx_r) < GRID_W) && (32'(fy_r) < GRID_H));
    sts.end_hit    = cell_hit;
    sts.zero_len   = (steps_r == '0);
    sts.walk_hit   = pend_r && cell_hit;
    sts.walk_done  = !(cnt_r < steps_r) && !pend_r;
  end

endmodule

// ===== sv/grid_segment_collision_check_core.sv =====
// Occupancy grid of GRID_W x GRID_H signed 8-bit cells with a segment collision check.
// A write transaction updates one cell and gives no result; an index off the grid is
// dropped. A check transaction returns one result: out of bounds, end cell occupied,
// path occupied or free. A check tests the end points for bounds first, then the end
// cell, and walks the path only when the end cell is free and the segment is not of
// zero length. The walk covers samples 0 (the start cell) to steps - 1, where steps
// is max(|dx|, |dy|), at most max(GRID_W, GRID_H) - 1, and stops at a path hit. The
// result goes valid in the same cycle that input can be taken again, and a result
// still stalled in the output register holds the check until it is taken. The walk
// samples one cell per cycle through the single read port of the grid memory, with
// the sample points tracked by incremental quotient/remainder counters. After reset
// the grid is cleared by a sweep over all GRID_W * GRID_H cells (4096 by default)
// during which no transaction is taken; obstacle_code is written on the cfg port and
// should change only while no check is in flight.
module grid_segment_collision_check_core #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gsc_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gsc_pkg::out_t     out_data,
  input  logic              cfg_wr_en,
  input  logic signed [7:0] cfg_wr_data
);
  import gsc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic     in_is_check;

  assign in_is_check = (in_data.cmd == CMD_CHECK);

  gsc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_is_check (in_is_check),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  gsc_dp #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_data)
  );

  // Busy right after a check transaction is taken
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd == CMD_CHECK) |=> in_stall)
    else $error("check accepted but input not stalled next cycle");

  // Blocked flag agrees with the reason code
  a_blocked_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.blocked == (out_data.reason != RS_FREE)))
    else $error("blocked flag and reason disagree");

  // Input held off while the grid is cleared after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // A result never appears without a check having been taken
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised while idle");

endmodule
